/* hdl/bffr_pkg.sv */
// ---------------------------------------------------------------------------
// bffr_pkg: shared types and constants for the first-fit free-run search
// Lane count, output widths, configuration register map and the records
// passed between the lane stage and the merge stage.
// ---------------------------------------------------------------------------
package bffr_pkg;

  localparam int LANES            = 8;
  localparam int LANE_BITS        = 3;
  localparam int CLUSTER_BITS_DEF = 48;
  localparam int RUN_LEN_W        = 32;
  localparam int CLUSTER_W        = 48;
  localparam int CFG_ADDR_W       = 3;
  localparam int CFG_DATA_W       = 48;
  localparam int NUM_RANGES       = 3;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_MIN_RUN_LENGTH = 3'd0,
    REG_MIN_START      = 3'd1,
    REG_EXCL0_BEGIN    = 3'd2,
    REG_EXCL0_END      = 3'd3,
    REG_EXCL1_BEGIN    = 3'd4,
    REG_EXCL1_END      = 3'd5,
    REG_EXCL2_BEGIN    = 3'd6,
    REG_EXCL2_END      = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic [CLUSTER_W-1:0] lo;
    logic [CLUSTER_W-1:0] hi;
  } range_t;

  typedef struct packed {
    logic [RUN_LEN_W-1:0] min_run_length;
    logic [CLUSTER_W-1:0] min_start;
    range_t [NUM_RANGES-1:0] excl;
  } cfg_t;

  // lane stage to merge stage
  typedef struct packed {
    logic             first;
    logic             last;
    logic [LANES-1:0] used;
  } lane_res_t;

endpackage

/* hdl/bffr_lane.sv */
// ---------------------------------------------------------------------------
// bffr_lane: usage decision for one cluster
// A cluster counts as used when its bitmap bit is set or when it falls in
// any of the exclude ranges (end exclusive, empty when end <= begin).
// ---------------------------------------------------------------------------
module bffr_lane #(
  parameter int CLUSTER_BITS = bffr_pkg::CLUSTER_BITS_DEF
) (
  input  logic [CLUSTER_BITS-1:0] cluster,
  input  logic                    map_bit,
  input  bffr_pkg::cfg_t          cfg,
  output logic                    used
);

  localparam int CW = (CLUSTER_BITS > bffr_pkg::CLUSTER_W) ? CLUSTER_BITS : bffr_pkg::CLUSTER_W;

  logic [CW-1:0]                       cl_ext;
  logic [bffr_pkg::NUM_RANGES-1:0]     in_rng;

  always_comb begin
    cl_ext = CW'(cluster);
    for (int r = 0; r < bffr_pkg::NUM_RANGES; r++) begin
      in_rng[r] = (cl_ext >= CW'(cfg.excl[r].lo)) && (cl_ext < CW'(cfg.excl[r].hi));
    end
    used = map_bit || (|in_rng);
  end

endmodule

/* hdl/bffr_merge.sv */
// ---------------------------------------------------------------------------
// bffr_merge: run tracking and result register
// Walks the eight lane decisions in cluster order, carries the free-run
// start across bytes, picks the first qualifying run end and holds the
// result until the downstream side takes it.
// ---------------------------------------------------------------------------
module bffr_merge #(
  parameter int CLUSTER_BITS = bffr_pkg::CLUSTER_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  bffr_pkg::cfg_t                    cfg,
  input  logic                              s1_valid,
  input  bffr_pkg::lane_res_t               s1_res,
  input  logic [CLUSTER_BITS-bffr_pkg::LANE_BITS-1:0] s1_blk,
  output logic                              s1_take,
  output logic                              res_valid,
  input  logic                              res_ready,
  output logic                              res_found,
  output logic [bffr_pkg::CLUSTER_W-1:0]    res_begin,
  output logic [bffr_pkg::CLUSTER_W-1:0]    res_end
);

  localparam int BW = CLUSTER_BITS - bffr_pkg::LANE_BITS;
  localparam int CW = (CLUSTER_BITS > bffr_pkg::CLUSTER_W) ? CLUSTER_BITS : bffr_pkg::CLUSTER_W;
  localparam int LW = (CLUSTER_BITS > bffr_pkg::RUN_LEN_W) ? CLUSTER_BITS : bffr_pkg::RUN_LEN_W;

  logic [CLUSTER_BITS-1:0] fsr_r, fsr_nxt;
  logic                    prev_r, prev_nxt;
  logic                    fin_r, fin_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic                    found_r, found_nxt;
  logic [CLUSTER_BITS-1:0] beg_r, beg_nxt;
  logic [CLUSTER_BITS-1:0] end_r, end_nxt;

  logic [CLUSTER_BITS-1:0] cl [bffr_pkg::LANES];
  logic [CLUSTER_BITS-1:0] st [bffr_pkg::LANES+1];
  logic [bffr_pkg::LANES:0] prv;
  logic [bffr_pkg::LANES-1:0] hit;
  logic [CLUSTER_BITS-1:0] len [bffr_pkg::LANES];
  logic [bffr_pkg::LANE_BITS-1:0] sel;
  logic                    fin_eff;
  logic [CLUSTER_BITS-1:0] tail_end;
  logic [CLUSTER_BITS-1:0] tail_len;
  logic                    tail_ok;
  logic                    out_free;
  logic [CW-1:0]           beg_ext, end_ext;

  assign out_free = !out_valid_r || res_ready;
  assign s1_take  = s1_valid && out_free;

  always_comb begin
    // a new scan restarts the tracking state before the byte is looked at
    st[0]   = s1_res.first ? '0 : fsr_r;
    prv[0]  = s1_res.first ? 1'b1 : prev_r;
    fin_eff = s1_res.first ? 1'b0 : fin_r;
    for (int unsigned i = 0; i < bffr_pkg::LANES; i++) begin
      cl[i]     = {s1_blk, bffr_pkg::LANE_BITS'(i)};
      len[i]    = cl[i] - st[i];
      hit[i]    = !prv[i] && s1_res.used[i]
                  && (CW'(st[i]) >= CW'(cfg.min_start))
                  && (LW'(len[i]) >= LW'(cfg.min_run_length));
      st[i+1]   = (prv[i] && !s1_res.used[i]) ? cl[i] : st[i];
      prv[i+1]  = s1_res.used[i];
    end
    sel = '0;
    for (int i = bffr_pkg::LANES - 1; i >= 0; i--) begin
      if (hit[i]) begin
        sel = bffr_pkg::LANE_BITS'(i);
      end
    end
    // run still open at the end of the final byte
    tail_end = {s1_blk + BW'(1), {bffr_pkg::LANE_BITS{1'b0}}};
    tail_len = tail_end - st[bffr_pkg::LANES];
    tail_ok  = !prv[bffr_pkg::LANES]
               && (CW'(st[bffr_pkg::LANES]) >= CW'(cfg.min_start))
               && (LW'(tail_len) >= LW'(cfg.min_run_length));
  end

  always_comb begin
    fsr_nxt       = fsr_r;
    prev_nxt      = prev_r;
    fin_nxt       = fin_r;
    found_nxt     = found_r;
    beg_nxt       = beg_r;
    end_nxt       = end_r;
    out_valid_nxt = out_valid_r && !res_ready;
    if (s1_take) begin
      fin_nxt  = fin_eff;
      fsr_nxt  = st[0];
      prev_nxt = prv[0];
      if (!fin_eff) begin
        if (|hit) begin
          fin_nxt       = 1'b1;
          out_valid_nxt = 1'b1;
          found_nxt     = 1'b1;
          beg_nxt       = st[sel];
          end_nxt       = cl[sel];
        end else begin
          fsr_nxt  = st[bffr_pkg::LANES];
          prev_nxt = prv[bffr_pkg::LANES];
          if (s1_res.last) begin
            fin_nxt       = 1'b1;
            out_valid_nxt = 1'b1;
            found_nxt     = tail_ok;
            beg_nxt       = tail_ok ? st[bffr_pkg::LANES] : '0;
            end_nxt       = tail_ok ? tail_end : '0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fsr_r       <= '0;
      prev_r      <= 1'b1;
      fin_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      fsr_r       <= fsr_nxt;
      prev_r      <= prev_nxt;
      fin_r       <= fin_nxt;
      out_valid_r <= out_valid_nxt;
    end
    found_r <= found_nxt;
    beg_r   <= beg_nxt;
    end_r   <= end_nxt;
  end

  assign beg_ext   = CW'(beg_r);
  assign end_ext   = CW'(end_r);
  assign res_valid = out_valid_r;
  assign res_found = found_r;
  assign res_begin = beg_ext[bffr_pkg::CLUSTER_W-1:0];
  assign res_end   = end_ext[bffr_pkg::CLUSTER_W-1:0];

endmodule

/* hdl/bitmap_first_fit_free_run_core.sv */
// ---------------------------------------------------------------------------
// bitmap_first_fit_free_run_core: first-fit free-run search over a bitmap
// Eight lanes judge the clusters of one bitmap byte in parallel, a merge
// stage tracks the current free run and reports the first qualifying one.
// ---------------------------------------------------------------------------
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+--------------------------------------
//  in_     | in  | in_tvalid/tready   | tdata: bitmap_byte; tuser: scan_first;
//          |     |                    | tlast: scan_last
//  out_    | out | out_tvalid/tready  | tdata: run_begin, run_end;
//          |     |                    | tuser: run_found
//  cfg_    | in  | cfg_we             | cfg_addr register index, cfg_wdata
//
// One request per cycle while the result side is not stalled; the request that
// causes a result passes the lane register, then the result register.
// The rate is set by the merge stage, which folds one whole byte into the
// run tracking state each cycle that a held result does not stall it.
// Reset is synchronous and takes effect at once; there is no clearing pass.
// A stalled result holds the merge stage and, through the lane register,
// the input side.
// ---------------------------------------------------------------------------
module bitmap_first_fit_free_run_core #(
  parameter int CLUSTER_BITS = bffr_pkg::CLUSTER_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [7:0]                        in_tdata,   // [7:0] bitmap_byte
  input  logic                              in_tuser,   // [0] scan_first
  input  logic                              in_tlast,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [95:0]                       out_tdata,  // [47:0] run_begin, [95:48] run_end
  output logic                              out_tuser,  // [0] run_found
  input  logic                              cfg_we,
  input  logic [bffr_pkg::CFG_ADDR_W-1:0]   cfg_addr,
  input  logic [bffr_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  localparam int BW = CLUSTER_BITS - bffr_pkg::LANE_BITS;

  bffr_pkg::cfg_t      cfg_r, cfg_nxt;
  logic [BW-1:0]       blk_cnt_r, blk_cnt_nxt;
  logic [BW-1:0]       blk_use;
  logic                s1_valid_r, s1_valid_nxt;
  bffr_pkg::lane_res_t s1_res_r, s1_res_nxt;
  logic [BW-1:0]       s1_blk_r, s1_blk_nxt;
  logic [bffr_pkg::LANES-1:0] lane_used;
  logic                s1_take;
  logic                in_acc;
  logic [bffr_pkg::CLUSTER_W-1:0] res_begin, res_end;

  // configuration registers
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (bffr_pkg::reg_idx_t'(cfg_addr))
        bffr_pkg::REG_MIN_RUN_LENGTH:
          cfg_nxt.min_run_length = cfg_wdata[bffr_pkg::RUN_LEN_W-1:0];
        bffr_pkg::REG_MIN_START:   cfg_nxt.min_start  = cfg_wdata;
        bffr_pkg::REG_EXCL0_BEGIN: cfg_nxt.excl[0].lo = cfg_wdata;
        bffr_pkg::REG_EXCL0_END:   cfg_nxt.excl[0].hi = cfg_wdata;
        bffr_pkg::REG_EXCL1_BEGIN: cfg_nxt.excl[1].lo = cfg_wdata;
        bffr_pkg::REG_EXCL1_END:   cfg_nxt.excl[1].hi = cfg_wdata;
        bffr_pkg::REG_EXCL2_BEGIN: cfg_nxt.excl[2].lo = cfg_wdata;
        bffr_pkg::REG_EXCL2_END:   cfg_nxt.excl[2].hi = cfg_wdata;
        default:                   cfg_nxt = cfg_r;
      endcase
    end
  end

  // byte counter: clusters of a byte share all but the low lane bits
  assign in_tready = !s1_valid_r || s1_take;
  assign in_acc    = in_tvalid && in_tready;
  assign blk_use   = in_tuser ? '0 : blk_cnt_r;

  genvar g;
  generate
    for (g = 0; g < bffr_pkg::LANES; g++) begin : g_lane
      bffr_lane #(
        .CLUSTER_BITS(CLUSTER_BITS)
      ) u_lane (
        .cluster (CLUSTER_BITS'({blk_use, bffr_pkg::LANE_BITS'(g)})),
        .map_bit (in_tdata[g]),
        .cfg     (cfg_r),
        .used    (lane_used[g])
      );
    end
  endgenerate

  always_comb begin
    blk_cnt_nxt  = blk_cnt_r;
    s1_res_nxt   = s1_res_r;
    s1_blk_nxt   = s1_blk_r;
    s1_valid_nxt = s1_valid_r && !s1_take;
    if (in_acc) begin
      blk_cnt_nxt      = blk_use + BW'(1);
      s1_valid_nxt     = 1'b1;
      s1_res_nxt.first = in_tuser;
      s1_res_nxt.last  = in_tlast;
      s1_res_nxt.used  = lane_used;
      s1_blk_nxt       = blk_use;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r      <= '0;
      blk_cnt_r  <= '0;
      s1_valid_r <= 1'b0;
    end else begin
      cfg_r      <= cfg_nxt;
      blk_cnt_r  <= blk_cnt_nxt;
      s1_valid_r <= s1_valid_nxt;
    end
    s1_res_r <= s1_res_nxt;
    s1_blk_r <= s1_blk_nxt;
  end

  bffr_merge #(
    .CLUSTER_BITS(CLUSTER_BITS)
  ) u_merge (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .s1_valid  (s1_valid_r),
    .s1_res    (s1_res_r),
    .s1_blk    (s1_blk_r),
    .s1_take   (s1_take),
    .res_valid (out_tvalid),
    .res_ready (out_tready),
    .res_found (out_tuser),
    .res_begin (res_begin),
    .res_end   (res_end)
  );

  assign out_tdata = {res_end, res_begin};

  // input side only waits on a held result
  a_in_stall_cause : assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (out_tvalid && !out_tready))
    else $error("input stalled without a held result");

  // a not-found report carries zero cluster numbers
  a_not_found_zero : assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tuser) |-> (out_tdata == '0))
    else $error("not-found result with nonzero payload");

  // nothing is reported right after reset
  a_reset_quiet : assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

/* tb/sv/tb_bitmap_first_fit_free_run_core.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_bitmap_first_fit_free_run_core: regression for the free-run search core
// Streams bitmap scans into the core and checks each reported run against a
// local fold of the bitmap, under several thresholds and exclude ranges and
// with random stalls on both the request and the result side.
// ---------------------------------------------------------------------------
module tb_bitmap_first_fit_free_run_core;

  localparam int unsigned RANDOM_BYTES = 1250;
  localparam int unsigned SETTLE_CYCLES = 6;
  localparam int unsigned CYCLE_LIMIT = 500000;
  localparam logic [47:0] CLUSTER_MAX = 48'hFFFF_FFFF_FFFF;

  typedef struct {
    bit          found;
    logic [47:0] run_lo;
    logic [47:0] run_hi;
  } run_report_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;   // [7:0] bitmap_byte
  logic        in_tuser;   // [0] scan_first
  logic        in_tlast;
  logic        out_tvalid;
  logic        out_tready;
  logic [95:0] out_tdata;  // [47:0] run_begin, [95:48] run_end
  logic        out_tuser;  // [0] run_found
  logic                            cfg_we;
  logic [bffr_pkg::CFG_ADDR_W-1:0] cfg_addr;
  logic [bffr_pkg::CFG_DATA_W-1:0] cfg_wdata;

  bitmap_first_fit_free_run_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // local copy of the register file
  logic [31:0] min_len_q;
  logic [47:0] min_start_q;
  logic [47:0] excl_lo_q [3];
  logic [47:0] excl_hi_q [3];

  // run tracking state
  logic [47:0] next_cl;
  logic [47:0] run_start;
  bit          prev_used;
  bit          scan_closed;

  bffr_pkg::reg_idx_t excl_begin_reg [3] = '{bffr_pkg::REG_EXCL0_BEGIN,
                                             bffr_pkg::REG_EXCL1_BEGIN,
                                             bffr_pkg::REG_EXCL2_BEGIN};
  bffr_pkg::reg_idx_t excl_end_reg   [3] = '{bffr_pkg::REG_EXCL0_END,
                                             bffr_pkg::REG_EXCL1_END,
                                             bffr_pkg::REG_EXCL2_END};

  run_report_t expected_runs[$];
  run_report_t want_run;
  int unsigned mismatches = 0;
  int unsigned bytes_folded = 0;
  int unsigned cycles = 0;
  bit          idle_en = 1'b1;

  function automatic bit is_excluded(input logic [47:0] cl);
    for (int r = 0; r < 3; r++) begin
      if (cl >= excl_lo_q[r] && cl < excl_hi_q[r]) return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic bit run_qualifies(input logic [47:0] stop);
    logic [47:0] run_len;
    run_len = stop - run_start;
    return (run_start >= min_start_q) && (run_len >= {16'd0, min_len_q});
  endfunction

  function automatic void push_run(input bit found, input logic [47:0] lo,
                                   input logic [47:0] hi);
    run_report_t rep;
    rep.found = found;
    rep.run_lo = lo;
    rep.run_hi = hi;
    expected_runs.push_back(rep);
  endfunction

  // folds one bitmap byte into the run state; returns 0 if the byte is ignored
  function automatic bit fold_bitmap_byte(input logic [7:0] bits, input bit first,
                                          input bit last);
    logic [47:0] cl;
    bit          used;
    if (first) begin
      next_cl = '0;
      run_start = '0;
      prev_used = 1'b1;
      scan_closed = 1'b0;
    end
    if (scan_closed) return 1'b0;
    for (int i = 0; i < 8; i++) begin
      cl = next_cl;
      used = bits[i] || is_excluded(cl);
      if (!prev_used && used && run_qualifies(cl)) begin
        push_run(1'b1, run_start, cl);
        scan_closed = 1'b1;
        return 1'b1;
      end
      if (prev_used && !used) run_start = cl;
      prev_used = used;
      next_cl = cl + 48'd1;
    end
    if (last) begin
      scan_closed = 1'b1;
      if (!prev_used && run_qualifies(next_cl)) push_run(1'b1, run_start, next_cl);
      else push_run(1'b0, '0, '0);
    end
    return 1'b1;
  endfunction

  task automatic report_mismatch(input string what, input logic [47:0] got,
                                 input logic [47:0] want);
    $display("mismatch: %s got %0h want %0h", what, got, want);
    mismatches++;
  endtask

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_runs.size() == 0) begin
        report_mismatch("result with none pending", out_tdata[47:0], '0);
      end else begin
        want_run = expected_runs.pop_front();
        if (out_tuser !== want_run.found)
          report_mismatch("run_found", 48'(out_tuser), 48'(want_run.found));
        if (out_tdata[47:0] !== want_run.run_lo)
          report_mismatch("run_begin", out_tdata[47:0], want_run.run_lo);
        if (out_tdata[95:48] !== want_run.run_hi)
          report_mismatch("run_end", out_tdata[95:48], want_run.run_hi);
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("bitmap_first_fit_free_run_core regression: fail");
      $finish;
    end
  end

  // result side backpressure
  initial begin
    int unsigned stall;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (idle_en && $urandom_range(0, 5) == 0) begin
        out_tready <= 1'b0;
        stall = $urandom_range(1, 13);
        repeat (stall) @(negedge clk);
      end
      out_tready <= 1'b1;
    end
  end

  // entered just after a rising edge; leaves tvalid high after the request
  task automatic send_byte(input logic [7:0] bits, input bit first, input bit last);
    int unsigned gap;
    @(negedge clk);
    if (idle_en && $urandom_range(0, 4) == 0) begin
      in_tvalid <= 1'b0;
      gap = $urandom_range(1, 13);
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= bits;
    in_tuser <= first;
    in_tlast <= last;
    do @(posedge clk); while (!in_tready);
    void'(fold_bitmap_byte(bits, first, last));
    bytes_folded++;
  endtask

  task automatic wait_drain();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (expected_runs.size() != 0) @(posedge clk);
    // a byte that reports nothing may still be in flight
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input bffr_pkg::reg_idx_t idx, input logic [47:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    case (idx)
      bffr_pkg::REG_MIN_RUN_LENGTH: min_len_q = val[31:0];
      bffr_pkg::REG_MIN_START:      min_start_q = val;
      bffr_pkg::REG_EXCL0_BEGIN:    excl_lo_q[0] = val;
      bffr_pkg::REG_EXCL0_END:      excl_hi_q[0] = val;
      bffr_pkg::REG_EXCL1_BEGIN:    excl_lo_q[1] = val;
      bffr_pkg::REG_EXCL1_END:      excl_hi_q[1] = val;
      bffr_pkg::REG_EXCL2_BEGIN:    excl_lo_q[2] = val;
      bffr_pkg::REG_EXCL2_END:      excl_hi_q[2] = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic test_reset_continuation();
    // no scan_first after reset: the scan runs on from cluster zero
    send_byte(8'h00, 1'b0, 1'b0);
    send_byte(8'h80, 1'b0, 1'b0);
    send_byte(8'h00, 1'b0, 1'b1);  // scan already closed
    wait_drain();
  endtask

  task automatic test_byte_extremes();
    send_byte(8'h00, 1'b1, 1'b1);
    send_byte(8'hFF, 1'b1, 1'b1);
    send_byte(8'hFE, 1'b1, 1'b1);
    send_byte(8'h7F, 1'b1, 1'b1);
    send_byte(8'hAA, 1'b1, 1'b0);
    send_byte(8'h00, 1'b1, 1'b1);  // restart before the old scan ended
    wait_drain();
  endtask

  task automatic test_run_thresholds();
    write_reg(bffr_pkg::REG_MIN_RUN_LENGTH, {16'd0, 32'hFFFF_FFFF});
    send_byte(8'h00, 1'b1, 1'b0);
    send_byte(8'h00, 1'b0, 1'b1);
    wait_drain();
    write_reg(bffr_pkg::REG_MIN_RUN_LENGTH, 48'd10);
    send_byte(8'hF0, 1'b1, 1'b0);
    send_byte(8'h00, 1'b0, 1'b0);
    send_byte(8'h00, 1'b0, 1'b1);
    wait_drain();
    write_reg(bffr_pkg::REG_MIN_RUN_LENGTH, 48'd0);
    write_reg(bffr_pkg::REG_MIN_START, CLUSTER_MAX);
    send_byte(8'h00, 1'b1, 1'b1);
    wait_drain();
    write_reg(bffr_pkg::REG_MIN_RUN_LENGTH, 48'd1);
    write_reg(bffr_pkg::REG_MIN_START, 48'd5);
    send_byte(8'h10, 1'b1, 1'b0);
    send_byte(8'h01, 1'b0, 1'b1);
    wait_drain();
  endtask

  task automatic test_exclude_ranges();
    write_reg(bffr_pkg::REG_MIN_START, 48'd0);
    write_reg(bffr_pkg::REG_EXCL0_BEGIN, 48'd3);
    write_reg(bffr_pkg::REG_EXCL0_END, 48'd6);
    send_byte(8'h00, 1'b1, 1'b1);
    wait_drain();
    write_reg(bffr_pkg::REG_EXCL1_BEGIN, 48'd0);
    write_reg(bffr_pkg::REG_EXCL1_END, 48'd2);
    send_byte(8'h00, 1'b1, 1'b1);
    wait_drain();
    write_reg(bffr_pkg::REG_EXCL0_END, 48'd0);
    write_reg(bffr_pkg::REG_EXCL2_BEGIN, 48'd10);
    write_reg(bffr_pkg::REG_EXCL2_END, CLUSTER_MAX);
    send_byte(8'h00, 1'b1, 1'b0);
    send_byte(8'h00, 1'b0, 1'b1);
    wait_drain();
    write_reg(bffr_pkg::REG_EXCL0_BEGIN, 48'd0);
    write_reg(bffr_pkg::REG_EXCL0_END, CLUSTER_MAX);
    send_byte(8'h00, 1'b1, 1'b1);
    wait_drain();
    // empty ranges: end below begin, end equal to begin
    write_reg(bffr_pkg::REG_EXCL0_BEGIN, 48'd20);
    write_reg(bffr_pkg::REG_EXCL0_END, 48'd5);
    write_reg(bffr_pkg::REG_EXCL1_BEGIN, 48'd7);
    write_reg(bffr_pkg::REG_EXCL1_END, 48'd7);
    write_reg(bffr_pkg::REG_EXCL2_BEGIN, CLUSTER_MAX);
    write_reg(bffr_pkg::REG_EXCL2_END, 48'd0);
    send_byte(8'h00, 1'b1, 1'b1);
    wait_drain();
  endtask

  function automatic logic [7:0] rand_bitmap_byte(input int unsigned mode);
    case (mode)
      0: return 8'($urandom);
      1: return 8'($urandom & $urandom);  // mostly free
      2: return 8'($urandom | $urandom);  // mostly used
      default: return ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
    endcase
  endfunction

  task automatic randomize_config();
    logic [47:0] lo;
    logic [47:0] hi;
    int unsigned k;
    case ($urandom_range(0, 5))
      0, 1: write_reg(bffr_pkg::REG_MIN_RUN_LENGTH, 48'd0);
      2, 3: write_reg(bffr_pkg::REG_MIN_RUN_LENGTH, 48'($urandom_range(1, 12)));
      4:    write_reg(bffr_pkg::REG_MIN_RUN_LENGTH, 48'($urandom_range(13, 70)));
      default: write_reg(bffr_pkg::REG_MIN_RUN_LENGTH,
                         {16'd0, 32'($urandom) | 32'h8000_0000});
    endcase
    case ($urandom_range(0, 4))
      0, 1: write_reg(bffr_pkg::REG_MIN_START, 48'd0);
      2, 3: write_reg(bffr_pkg::REG_MIN_START, 48'($urandom_range(1, 60)));
      default: write_reg(bffr_pkg::REG_MIN_START, CLUSTER_MAX);
    endcase
    for (int r = 0; r < 3; r++) begin
      case ($urandom_range(0, 4))
        0: begin
          lo = 48'($urandom_range(0, 100));
          k = $urandom_range(0, 3);
          hi = (lo >= 48'(k)) ? lo - 48'(k) : lo;
        end
        1, 2: begin
          lo = 48'($urandom_range(0, 100));
          hi = lo + 48'($urandom_range(1, 12));
        end
        3: begin
          lo = 48'($urandom_range(40, 110));
          hi = CLUSTER_MAX;
        end
        default: begin
          // far above any scanned cluster
          lo = {16'($urandom) | 16'h8000, 32'($urandom)};
          hi = CLUSTER_MAX;
        end
      endcase
      write_reg(excl_begin_reg[r], lo);
      write_reg(excl_end_reg[r], hi);
    end
  endtask

  task automatic send_scan();
    int unsigned nbytes;
    int unsigned mode;
    int unsigned strays;
    bit          drop_last;
    nbytes = $urandom_range(1, 12);
    if ($urandom_range(0, 7) == 0) nbytes = $urandom_range(13, 16);
    mode = $urandom_range(0, 3);
    drop_last = ($urandom_range(0, 9) == 0);
    for (int i = 0; i < nbytes; i++)
      send_byte(rand_bitmap_byte(mode), i == 0, (i == nbytes - 1) && !drop_last);
    // noise between scans
    if ($urandom_range(0, 5) == 0) begin
      strays = $urandom_range(1, 3);
      repeat (strays) send_byte(8'($urandom), 1'b0, 1'($urandom));
    end
  endtask

  task automatic test_random_scans();
    int unsigned base;
    int unsigned phase_end;
    base = bytes_folded;
    while (bytes_folded - base < RANDOM_BYTES) begin
      wait_drain();
      randomize_config();
      // the tail of the run goes without stalls
      if (bytes_folded - base + 150 >= RANDOM_BYTES) idle_en = 1'b0;
      else idle_en = ($urandom_range(0, 4) != 0);
      phase_end = bytes_folded + $urandom_range(80, 140);
      while (bytes_folded < phase_end && bytes_folded - base < RANDOM_BYTES)
        send_scan();
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = 1'b0;
    in_tlast = 1'b0;
    cfg_we = 1'b0;
    cfg_addr = bffr_pkg::REG_MIN_RUN_LENGTH;
    cfg_wdata = '0;
    min_len_q = '0;
    min_start_q = '0;
    for (int r = 0; r < 3; r++) begin
      excl_lo_q[r] = '0;
      excl_hi_q[r] = '0;
    end
    next_cl = '0;
    run_start = '0;
    prev_used = 1'b1;
    scan_closed = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_continuation();
    test_byte_extremes();
    test_run_thresholds();
    test_exclude_ranges();
    test_random_scans();

    wait_drain();
    if (mismatches == 0) begin
      $display("bitmap_first_fit_free_run_core regression: pass");
    end else begin
      $display("bitmap_first_fit_free_run_core regression: fail");
    end
    $finish;
  end

endmodule
